### rtl/lz77d_pkg.sv
package lz77d_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_W        = $clog2(WINDOW_DEPTH);
  localparam int SIZE_BITS    = 24;
  localparam int RAW_SIZE_W   = 24;
  localparam int LEN_W        = 5;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);

  localparam logic [7:0]           HDR_LZ77    = 8'h10;
  localparam logic [7:0]           HDR_NONE    = 8'h00;
  localparam logic [LEN_W-1:0]     MIN_MATCH   = LEN_W'(3);
  localparam logic [3:0]           FLAG_COUNT  = 4'd8;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX    = '1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIZE0,
    PH_SIZE1,
    PH_SIZE2,
    PH_TOKEN,
    PH_LOW
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [WIN_W-1:0] disp;
    logic [LEN_W-1:0] len;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/lz77d_channels.sv
interface lz77d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink (input valid, input in_byte, input stream_start, output ready);
endinterface

interface lz77d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, output out_byte, output last, output error, input ready);
  modport sink (input valid, input out_byte, input last, input error, output ready);
endinterface

### rtl/lz77d_front.sv
module lz77d_front (
  input  logic                 clk,
  input  logic                 rst,
  lz77d_in_if.sink             comp,
  input  lz77d_pkg::q_status_t q_stat,
  output logic                 push,
  output lz77d_pkg::cmd_t      cmd
);
  import lz77d_pkg::*;

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  remaining, remaining_next;
  logic [SIZE_BITS-1:0]  produced, produced_next;
  logic [7:0]            flag_bits, flag_bits_next;
  logic [3:0]            flag_index, flag_index_next;
  logic [7:0]            held_high, held_high_next;
  logic [15:0]           size_lo, size_lo_next;

  logic                  take;
  logic [WIN_W-1:0]      disp;
  logic [LEN_W-1:0]      ref_len;
  logic [LEN_W-1:0]      copy_len;
  logic                  ref_bad;
  logic                  copy_last;
  logic [RAW_SIZE_W-1:0] size_full;
  logic [SIZE_BITS-1:0]  size_sat;

  assign comp.ready = !q_stat.full;
  assign take       = comp.valid && comp.ready;

  assign disp      = {held_high[3:0], comp.in_byte};
  assign ref_len   = {1'b0, held_high[7:4]} + MIN_MATCH;
  assign ref_bad   = (SIZE_BITS'(disp) + SIZE_BITS'(1)) > produced;
  assign copy_last = remaining <= SIZE_BITS'(ref_len);
  assign copy_len  = copy_last ? remaining[LEN_W-1:0] : ref_len;
  assign size_full = {comp.in_byte, size_lo};
  assign size_sat  = (size_full > RAW_SIZE_W'(SIZE_MAX)) ? SIZE_MAX
                                                        : size_full[SIZE_BITS-1:0];

  always_comb begin
    phase_next = phase;
    if (take) begin
      if (comp.stream_start) begin
        phase_next = (comp.in_byte == HDR_LZ77) ? PH_SIZE0 : PH_IDLE;
      end else begin
        unique case (phase)
          PH_IDLE:  phase_next = PH_IDLE;
          PH_SIZE0: phase_next = PH_SIZE1;
          PH_SIZE1: phase_next = PH_SIZE2;
          PH_SIZE2: phase_next = (size_sat == '0) ? PH_IDLE : PH_TOKEN;
          PH_TOKEN: begin
            if (flag_index != '0) begin
              if (flag_bits[7]) begin
                phase_next = PH_LOW;
              end else if (remaining == SIZE_BITS'(1)) begin
                phase_next = PH_IDLE;
              end
            end
          end
          PH_LOW:   phase_next = (ref_bad || copy_last) ? PH_IDLE : PH_TOKEN;
          default:  phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    remaining_next  = remaining;
    produced_next   = produced;
    flag_bits_next  = flag_bits;
    flag_index_next = flag_index;
    held_high_next  = held_high;
    size_lo_next    = size_lo;
    push            = 1'b0;
    cmd             = '0;
    if (take) begin
      if (comp.stream_start) begin
        remaining_next  = '0;
        produced_next   = '0;
        flag_bits_next  = '0;
        flag_index_next = '0;
        held_high_next  = '0;
        if (comp.in_byte != HDR_NONE && comp.in_byte != HDR_LZ77) begin
          push      = 1'b1;
          cmd.kind  = CMD_ERR;
          cmd.last  = 1'b1;
        end
      end else begin
        unique case (phase)
          PH_IDLE:  ;
          PH_SIZE0: size_lo_next = {8'h00, comp.in_byte};
          PH_SIZE1: size_lo_next[15:8] = comp.in_byte;
          PH_SIZE2: remaining_next = size_sat;
          PH_TOKEN: begin
            if (flag_index == '0) begin
              flag_bits_next  = comp.in_byte;
              flag_index_next = FLAG_COUNT;
            end else if (!flag_bits[7]) begin
              flag_bits_next  = {flag_bits[6:0], 1'b0};
              flag_index_next = flag_index - 4'd1;
              push            = 1'b1;
              cmd.kind        = CMD_LIT;
              cmd.data        = comp.in_byte;
              cmd.last        = remaining == SIZE_BITS'(1);
              remaining_next  = remaining - SIZE_BITS'(1);
              produced_next   = produced + SIZE_BITS'(1);
            end else begin
              held_high_next = comp.in_byte;
            end
          end
          PH_LOW: begin
            flag_bits_next  = {flag_bits[6:0], 1'b0};
            flag_index_next = flag_index - 4'd1;
            push            = 1'b1;
            if (ref_bad) begin
              cmd.kind = CMD_ERR;
              cmd.last = 1'b1;
            end else begin
              cmd.kind       = CMD_COPY;
              cmd.disp       = disp;
              cmd.len        = copy_len;
              cmd.last       = copy_last;
              remaining_next = remaining - SIZE_BITS'(copy_len);
              produced_next  = produced + SIZE_BITS'(copy_len);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      remaining  <= '0;
      produced   <= '0;
      flag_bits  <= '0;
      flag_index <= '0;
      held_high  <= '0;
    end else begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      produced   <= produced_next;
      flag_bits  <= flag_bits_next;
      flag_index <= flag_index_next;
      held_high  <= held_high_next;
    end
  end

  always_ff @(posedge clk) begin
    size_lo <= size_lo_next;
  end

endmodule

### rtl/lz77d_cmd_fifo.sv
module lz77d_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lz77d_pkg::cmd_t      wr_cmd,
  input  logic                 pop,
  output lz77d_pkg::cmd_t      head,
  output lz77d_pkg::q_status_t q_stat
);
  import lz77d_pkg::*;

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = count == (Q_PTR_W+1)'(Q_DEPTH);
  assign q_stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

### rtl/lz77d_back.sv
module lz77d_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lz77d_pkg::cmd_t      head,
  input  lz77d_pkg::q_status_t q_stat,
  output logic                 pop,
  lz77d_out_if.source          plain
);
  import lz77d_pkg::*;

  back_state_t      state, state_next;
  logic [7:0]       window [WINDOW_DEPTH];
  logic [WIN_W-1:0] wptr;
  logic [WIN_W-1:0] rptr;
  logic [LEN_W-1:0] copy_left;
  logic             copy_last;
  logic [7:0]       rdata;

  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             out_error;

  logic             slot_free;
  logic             load;
  logic [7:0]       ld_byte;
  logic             ld_last;
  logic             ld_error;
  logic             mem_we;
  logic             start_copy;
  logic             step_copy;

  assign slot_free      = !out_valid || plain.ready;
  assign plain.valid    = out_valid;
  assign plain.out_byte = out_byte;
  assign plain.last     = out_last;
  assign plain.error    = out_error;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty && head.kind == CMD_COPY) begin
          state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_EMIT;
      BK_EMIT: begin
        if (slot_free) begin
          state_next = (copy_left == LEN_W'(1)) ? BK_IDLE : BK_READ;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    load       = 1'b0;
    ld_byte    = '0;
    ld_last    = 1'b0;
    ld_error   = 1'b0;
    mem_we     = 1'b0;
    start_copy = 1'b0;
    step_copy  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          unique case (head.kind)
            CMD_LIT: begin
              if (slot_free) begin
                pop     = 1'b1;
                load    = 1'b1;
                ld_byte = head.data;
                ld_last = head.last;
                mem_we  = 1'b1;
              end
            end
            CMD_ERR: begin
              if (slot_free) begin
                pop      = 1'b1;
                load     = 1'b1;
                ld_last  = 1'b1;
                ld_error = 1'b1;
              end
            end
            CMD_COPY: begin
              pop        = 1'b1;
              start_copy = 1'b1;
            end
            default: ;
          endcase
        end
      end
      BK_READ: ;
      BK_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_byte   = rdata;
          ld_last   = copy_last && (copy_left == LEN_W'(1));
          mem_we    = 1'b1;
          step_copy = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      wptr      <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (plain.ready) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        wptr <= wptr + WIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= ld_byte;
      out_last  <= ld_last;
      out_error <= ld_error;
    end
    if (start_copy) begin
      rptr      <= wptr - head.disp - WIN_W'(1);
      copy_left <= head.len;
      copy_last <= head.last;
    end else if (step_copy) begin
      rptr      <= rptr + WIN_W'(1);
      copy_left <= copy_left - LEN_W'(1);
    end
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      window[wptr] <= ld_byte;
    end
    if (state == BK_READ) begin
      rdata <= window[rptr];
    end
  end

endmodule

### rtl/lz77_stream_decompressor_unit.sv
// LZ77 (type 0x10) stream decompressor with a 4096-byte history window. Compressed
// bytes enter on comp, one per item, with stream_start on the header byte; decoded
// bytes leave on plain, with last on the final byte of a stream and error (byte 0,
// last 1) for a bad header or a reference before the start of output. The parser
// takes one item per cycle as long as its 4-entry command queue has room; a valid
// header, size and flag bytes produce nothing. The output side writes a literal to
// the window and presents it once the output slot is free. A reference is taken from
// the queue in BK_IDLE; then each byte is read from the window memory in BK_READ and
// written back and presented in BK_EMIT, which waits while the output is stalled, so
// the copy loop sets the sustained rate. No clearing pass after reset.
module lz77_stream_decompressor_unit (
  input  logic        clk,
  input  logic        rst,
  lz77d_in_if.sink    comp,
  lz77d_out_if.source plain
);
  import lz77d_pkg::*;

  logic      push;
  logic      pop;
  cmd_t      wr_cmd;
  cmd_t      head;
  q_status_t q_stat;

  lz77d_front u_front (
    .clk    (clk),
    .rst    (rst),
    .comp   (comp),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (wr_cmd)
  );

  lz77d_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  lz77d_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .plain  (plain)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  a_err_item: assert property (@(posedge clk) disable iff (rst)
    (plain.valid && plain.error) |-> (plain.out_byte == 8'h00 && plain.last))
    else $error("error item without zero byte and last");

endmodule
